@@ src/bhd_pkg.sv @@
// shared types, constants and codes of the block holder directory
`default_nettype none

package bhd_pkg;

  localparam int unsigned BHD_NUM_BLOCKS  = 4096;
  localparam int unsigned BHD_MAX_HOLDERS = 8;

  localparam int unsigned BLK_W  = 12;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned RND_W  = 16;
  localparam int unsigned CFG_W  = 4;

  localparam logic [CFG_W-1:0] DEFAULT_HOLDERS = 4'd2;

  // remainder unit retires this many dividend bits per cycle
  localparam int unsigned REM_STEP_BITS = 4;

  typedef enum logic {
    REQ_LOOKUP  = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_WRITE
  } state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [BLK_W-1:0]   block_index;
    logic [ID_W-1:0]    requester_id;
    logic [SLOT_W-1:0]  requester_slot;
    logic [RND_W-1:0]   random_value;
  } req_t;

  typedef struct packed {
    logic               holder_found;
    logic [ID_W-1:0]    holder_id;
    logic [SLOT_W-1:0]  holder_slot;
    logic               entry_removed;
  } rsp_t;

endpackage

`default_nettype wire

@@ src/bhd_rem.sv @@
// iterative remainder unit: dividend modulo a narrow divisor, a few bits per cycle
`default_nettype none

module bhd_rem import bhd_pkg::*; #(
  parameter int unsigned DivW     = RND_W,
  parameter int unsigned StepBits = REM_STEP_BITS,
  parameter int unsigned DsrW     = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DsrW-1:0] rem_o
);

  localparam int unsigned Steps = DivW / StepBits;
  localparam int unsigned StepW = (Steps > 1) ? $clog2(Steps) : 1;

  logic            busy_q;
  logic            done_q;
  logic [StepW-1:0] step_q;
  logic [DivW-1:0] num_q;
  logic [DsrW-1:0] rem_q;
  logic [DsrW-1:0] dsr_q;

  logic [DsrW:0]   rem_nx;
  logic [DivW-1:0] num_nx;

  // restoring remainder, msb first
  always_comb begin
    rem_nx = {1'b0, rem_q};
    num_nx = num_q;
    for (int k = 0; k < int'(StepBits); k++) begin
      rem_nx = {rem_nx[DsrW-1:0], num_nx[DivW-1]};
      num_nx = {num_nx[DivW-2:0], 1'b0};
      if (rem_nx >= {1'b0, dsr_q}) begin
        rem_nx = rem_nx - {1'b0, dsr_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_nx;
      rem_q <= rem_nx[DsrW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ src/block_holder_directory_core.sv @@
// block holder directory: per-block holder lists kept in one row memory
// flow: a taken item is read from its row in S_READ and its result is registered in S_WRITE;
//   a lookup of a block with holders first waits in S_DIV for the remainder unit (4 steps of 4 bits)
// no new item is taken until the last one has left S_WRITE, which waits while the output stalls; each
//   item reads one row, and an in-range lookup or a successful release rewrites and writes it back
// reset: a clearing pass zeroes the count of every row while no item is taken; the capacity
//   register resets to 2
`default_nettype none

module block_holder_directory_core import bhd_pkg::*; #(
  parameter int unsigned NumBlocks  = BHD_NUM_BLOCKS,
  parameter int unsigned MaxHolders = BHD_MAX_HOLDERS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned CntW  = $clog2(MaxHolders + 1);
  localparam int unsigned PosW  = (MaxHolders > 1) ? $clog2(MaxHolders) : 1;
  localparam int unsigned RowW  = CntW + MaxHolders * (ID_W + SLOT_W);

  typedef logic [MaxHolders-1:0][ID_W-1:0]   ids_t;
  typedef logic [MaxHolders-1:0][SLOT_W-1:0] slots_t;

  state_e state_q, state_d;

  logic [CFG_W-1:0] cfg_q;
  logic [AddrW-1:0] clr_q;
  logic             clr_last;
  req_t             req_q;
  logic             in_range_q;
  logic             out_valid_q;
  rsp_t             out_q, rsp_d;

  logic [RowW-1:0]  mem_q [NumBlocks];
  logic [RowW-1:0]  rdata_q;
  logic             mem_re, mem_we;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  logic [RowW-1:0]  mem_wdata;

  logic [31:0]      in_blk_ext, req_blk_ext;

  logic             out_free, commit, rem_start, rem_done;
  logic [CntW-1:0]  rem_val;

  logic [CntW-1:0]  cnt_rd, cnt_c, cap, drop, keep, cnt_nx;
  ids_t             ids_rd, ids_sh, ids_nx;
  slots_t           slots_rd, slots_sh, slots_nx;
  logic [MaxHolders-1:0] match;
  logic             rel_found;
  logic [PosW-1:0]  rel_pos;
  logic [CntW:0]    src;
  logic             is_lookup;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= DEFAULT_HOLDERS;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign in_blk_ext  = 32'(in_data_i.block_index);
  assign req_blk_ext = 32'(req_q.block_index);
  assign clr_last    = (clr_q == AddrW'(NumBlocks - 1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_lookup   = (req_q.req_type == REQ_LOOKUP);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = rem_start ? S_DIV : S_WRITE;
      S_DIV:   if (rem_done) state_d = S_WRITE;
      S_WRITE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    rem_start  = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        mem_re     = in_valid_i;
      end
      S_READ:  rem_start = in_range_q && is_lookup && (cnt_c != '0);
      S_WRITE: commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      req_q      <= in_data_i;
      in_range_q <= (in_blk_ext < 32'(NumBlocks));
    end
    if (commit) begin
      out_q <= rsp_d;
    end
  end

  // row memory: {count, ids, slots}
  assign mem_raddr = in_blk_ext[AddrW-1:0];
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : req_blk_ext[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign {cnt_rd, ids_rd, slots_rd} = rdata_q;
  assign cnt_c    = (cnt_rd > CntW'(MaxHolders)) ? CntW'(MaxHolders) : cnt_rd;
  assign ids_sh   = ids_rd >> ID_W;
  assign slots_sh = slots_rd >> SLOT_W;

  always_comb begin
    if (cfg_q == '0) begin
      cap = CntW'(1);
    end else if (32'(cfg_q) > 32'(MaxHolders)) begin
      cap = CntW'(MaxHolders);
    end else begin
      cap = CntW'(cfg_q);
    end
  end

  bhd_rem #(
    .DivW     (RND_W),
    .StepBits (REM_STEP_BITS),
    .DsrW     (CntW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (req_q.random_value),
    .divisor_i  (cnt_c),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // release: first pair of the requester
  always_comb begin
    for (int i = 0; i < int'(MaxHolders); i++) begin
      match[i] = (CntW'(i) < cnt_c) && (ids_rd[i] == req_q.requester_id);
    end
    rel_found = |match;
    rel_pos   = '0;
    for (int i = int'(MaxHolders) - 1; i >= 0; i--) begin
      if (match[i]) rel_pos = PosW'(i);
    end
  end

  // lookup: drop the oldest pairs when full, then append
  assign drop = (cnt_c >= cap) ? (cnt_c - cap + CntW'(1)) : '0;
  assign keep = (cnt_c >= cap) ? (cap - CntW'(1)) : cnt_c;

  always_comb begin
    ids_nx   = ids_rd;
    slots_nx = slots_rd;
    src      = '0;
    if (is_lookup) begin
      for (int i = 0; i < int'(MaxHolders); i++) begin
        src = (CntW + 1)'(i) + {1'b0, drop};
        if (src < (CntW + 1)'(MaxHolders)) begin
          ids_nx[i]   = ids_rd[src[PosW-1:0]];
          slots_nx[i] = slots_rd[src[PosW-1:0]];
        end
      end
      ids_nx[keep[PosW-1:0]]   = req_q.requester_id;
      slots_nx[keep[PosW-1:0]] = req_q.requester_slot;
      cnt_nx = keep + CntW'(1);
    end else begin
      for (int i = 0; i < int'(MaxHolders); i++) begin
        if (PosW'(i) >= rel_pos) begin
          ids_nx[i]   = ids_sh[i];
          slots_nx[i] = slots_sh[i];
        end
      end
      cnt_nx = cnt_c - CntW'(1);
    end
  end

  assign mem_we    = (state_q == S_CLEAR) ||
                     (commit && in_range_q && (is_lookup || rel_found));
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : {cnt_nx, ids_nx, slots_nx};

  always_comb begin
    rsp_d = '0;
    if (in_range_q) begin
      if (is_lookup) begin
        if (cnt_c != '0) begin
          rsp_d.holder_found = 1'b1;
          rsp_d.holder_id    = ids_rd[rem_val[PosW-1:0]];
          rsp_d.holder_slot  = slots_rd[rem_val[PosW-1:0]];
        end
      end else begin
        rsp_d.entry_removed = rel_found;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.holder_found && out_data_o.entry_removed))
    else $error("result reports both a holder and a removal");

  a_take_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_READ))
    else $error("taken item did not start a row read");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (rem_val < cnt_c))
    else $error("chosen position not below holder count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_wdata[RowW-1 -: CntW] <= CntW'(MaxHolders)))
    else $error("holder count written above list size");
`endif

endmodule

`default_nettype wire
